// ----- src/tlvd_pkg.sv -----
// Shared types and constants of the TLV stream deframer.
package tlvd_pkg;

	// Width of the length field on the wire, in bytes (1 or 2).
	localparam int LEN_BYTES = 2;
	localparam logic [1:0] LEN_BYTES_C = 2'(LEN_BYTES);

	// Register value that selects a one-byte type field; anything else means two.
	localparam logic [1:0] TB_ONE_BYTE = 2'd1;
	localparam logic [1:0] TB_RESET = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_VALUE_CUT = 2'd1;
	localparam logic [1:0] ST_HEADER_CUT = 2'd2;

	typedef enum logic [2:0] {
		PH_TYPE = 3'b001,
		PH_LEN = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [15:0] rec_type;
		logic [15:0] rec_length;
		logic [7:0] value_byte;
		logic has_byte;
		logic rec_last;
		logic [1:0] status;
		logic buffer_done;
	} res_t;

endpackage

// ----- src/tlvd_in_reg.sv -----
// Input register stage of the TLV stream deframer.
module tlvd_in_reg import tlvd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic buffer_end,
	input logic advance,
	output logic valid_s1,
	output logic [7:0] byte_s1,
	output logic end_s1
);

	logic accept;

	// The stage can take a beat when it is empty or is being consumed now.
	assign in_stall = valid_s1 & ~advance;
	assign accept = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			end_s1 <= buffer_end;
		end
	end

endmodule

// ----- src/tlvd_parse.sv -----
// Record parser of the TLV stream deframer: header gathering, value counting, result forming.
module tlvd_parse import tlvd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_wdata,
	input logic fire,
	input logic [7:0] byte_s1,
	input logic end_s1,
	output logic produce,
	output res_t res
);

	logic [1:0] type_bytes_q;
	phase_t phase_q, phase_d;
	logic [1:0] count_q, count_d;
	logic [15:0] type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [15:0] left_q, left_d;

	logic [1:0] type_width;
	logic [1:0] count_inc;
	logic [15:0] type_shift;
	logic [15:0] len_shift;
	logic [15:0] left_dec;
	logic val_last;

	assign type_width = (type_bytes_q == TB_ONE_BYTE) ? 2'd1 : 2'd2;
	assign count_inc = count_q + 2'd1;
	assign type_shift = {type_q[7:0], byte_s1};
	assign len_shift = {len_q[7:0], byte_s1};
	assign left_dec = left_q - 16'd1;
	assign val_last = (left_dec == 16'd0) | end_s1;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		type_d = type_q;
		len_d = len_q;
		left_d = left_q;
		produce = 1'b0;
		res = '0;
		case (phase_q)
			PH_TYPE: begin
				if (end_s1) begin
					count_d = 2'd0;
					type_d = '0;
					len_d = '0;
					left_d = '0;
					produce = 1'b1;
					res.rec_last = 1'b1;
					res.status = ST_HEADER_CUT;
					res.buffer_done = 1'b1;
				end else if (count_inc >= type_width) begin
					phase_d = PH_LEN;
					count_d = 2'd0;
					type_d = type_shift;
				end else begin
					count_d = count_inc;
					type_d = type_shift;
				end
			end
			PH_LEN: begin
				if (count_inc >= LEN_BYTES_C) begin
					if (len_shift == 16'd0 || end_s1) begin
						// Empty record, or a full header that ends the buffer.
						phase_d = PH_TYPE;
						count_d = 2'd0;
						type_d = '0;
						len_d = '0;
						left_d = '0;
						produce = 1'b1;
						res.rec_type = type_q;
						res.rec_length = len_shift;
						res.rec_last = 1'b1;
						res.status = (len_shift == 16'd0) ? ST_OK : ST_VALUE_CUT;
						res.buffer_done = end_s1;
					end else begin
						phase_d = PH_VALUE;
						count_d = 2'd0;
						len_d = len_shift;
						left_d = len_shift;
					end
				end else if (end_s1) begin
					phase_d = PH_TYPE;
					count_d = 2'd0;
					type_d = '0;
					len_d = '0;
					left_d = '0;
					produce = 1'b1;
					res.rec_last = 1'b1;
					res.status = ST_HEADER_CUT;
					res.buffer_done = 1'b1;
				end else begin
					count_d = count_inc;
					len_d = len_shift;
				end
			end
			PH_VALUE: begin
				produce = 1'b1;
				res.rec_type = type_q;
				res.rec_length = len_q;
				res.value_byte = byte_s1;
				res.has_byte = 1'b1;
				res.rec_last = val_last;
				res.status = (end_s1 && left_dec != 16'd0) ? ST_VALUE_CUT : ST_OK;
				res.buffer_done = end_s1;
				if (val_last) begin
					phase_d = PH_TYPE;
					count_d = 2'd0;
					type_d = '0;
					len_d = '0;
					left_d = '0;
				end else begin
					left_d = left_dec;
				end
			end
			default: begin
				phase_d = PH_TYPE;
				count_d = 2'd0;
				type_d = '0;
				len_d = '0;
				left_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_bytes_q <= TB_RESET;
		end else if (cfg_we) begin
			type_bytes_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			count_q <= 2'd0;
			type_q <= '0;
			len_q <= '0;
			left_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			count_q <= count_d;
			type_q <= type_d;
			len_q <= len_d;
			left_q <= left_d;
		end
	end

endmodule

// ----- src/tlvd_out_reg.sv -----
// Result register of the TLV stream deframer.
module tlvd_out_reg import tlvd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic produce,
	input res_t res,
	output logic room,
	output logic out_valid,
	input logic out_stall,
	output res_t res_q
);

	logic out_valid_q;

	// The register frees up in the same cycle that its beat is taken.
	assign room = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (room) begin
			out_valid_q <= load & produce;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- src/tlv_stream_deframer.sv -----
// Top level of the TLV stream deframer.
//
// The block splits a byte stream of type-length-value records. The input
// channel (in_valid, in_stall, data_byte, buffer_end) moves one buffer byte
// per beat; buffer_end marks the last byte of a buffer. Each record is a
// big-endian type of one or two bytes (set by cfg_wdata when cfg_we is high,
// reset value two), a big-endian length of LEN_BYTES bytes and the value.
// The output channel (out_valid, out_stall and the result fields) gives one
// beat per value byte, one beat with has_byte low for an empty record, and
// one status beat when a buffer ends inside a header or cuts a value short.
// Header bytes produce no beat otherwise.
//
// An accepted byte is held in the input stage, parsed there, and its result
// is loaded into the result register, which offers it as an output beat.
// The block takes one byte per clock; the single input stage and the result
// register keep that rate while the receiver takes beats. When out_stall is
// high with a result waiting, the input stage fills and in_stall rises on the
// next byte; no result is dropped and the held result does not change.
// Asynchronous reset empties both registers, sets the type width to two
// bytes and starts parsing at a record's type field.
module tlv_stream_deframer import tlvd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic buffer_end,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] rec_type,
	output logic [15:0] rec_length,
	output logic [7:0] value_byte,
	output logic has_byte,
	output logic rec_last,
	output logic [1:0] status,
	output logic buffer_done
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic end_s1;
	logic room;
	logic advance;
	logic produce;
	res_t res;
	res_t res_q;

	// A staged byte is parsed whenever the result register can take its outcome.
	assign advance = valid_s1 & room;

	tlvd_in_reg u_in_reg (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.buffer_end(buffer_end),
		.advance(advance),
		.valid_s1(valid_s1),
		.byte_s1(byte_s1),
		.end_s1(end_s1)
	);

	tlvd_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fire(advance),
		.byte_s1(byte_s1),
		.end_s1(end_s1),
		.produce(produce),
		.res(res)
	);

	tlvd_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.produce(produce),
		.res(res),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res_q(res_q)
	);

	assign rec_type = res_q.rec_type;
	assign rec_length = res_q.rec_length;
	assign value_byte = res_q.value_byte;
	assign has_byte = res_q.has_byte;
	assign rec_last = res_q.rec_last;
	assign status = res_q.status;
	assign buffer_done = res_q.buffer_done;

endmodule

// ----- src/tlvd_checker.sv -----
// Port-level checks of the TLV stream deframer and their binding.
module tlvd_checker import tlvd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [15:0] rec_type,
	input logic [15:0] rec_length,
	input logic [7:0] value_byte,
	input logic has_byte,
	input logic rec_last,
	input logic [1:0] status,
	input logic buffer_done
);

	// A stalled result beat stays and holds its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rec_type) && $stable(rec_length)
			&& $stable(value_byte) && $stable(has_byte) && $stable(rec_last)
			&& $stable(status) && $stable(buffer_done))
		else $error("stalled result beat changed");

	// A beat inside a record always carries a byte and a good status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rec_last |-> has_byte && status == ST_OK && !buffer_done)
		else $error("record continues with bad beat");

	// A dropped header reports no type or length and ends the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_HEADER_CUT |-> rec_type == 16'd0 && rec_length == 16'd0
			&& !has_byte && rec_last && buffer_done)
		else $error("header cut beat malformed");

	// A cut value closes the record at the buffer end.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_VALUE_CUT |-> rec_last && buffer_done && rec_length != 16'd0)
		else $error("value cut beat malformed");

	// A byteless good beat is an empty record.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte && status == ST_OK |-> rec_last && rec_length == 16'd0)
		else $error("empty record beat malformed");

endmodule

bind tlv_stream_deframer tlvd_checker u_tlvd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.rec_type(rec_type),
	.rec_length(rec_length),
	.value_byte(value_byte),
	.has_byte(has_byte),
	.rec_last(rec_last),
	.status(status),
	.buffer_done(buffer_done)
);
